@@ rtl/sbd_pkg.sv @@
package sbd_pkg;

   // detector modes
   localparam logic [1:0] MODE_WAITING    = 2'd0;
   localparam logic [1:0] MODE_EVALUATION = 2'd1;
   localparam logic [1:0] MODE_TRACKING   = 2'd2;

   // register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SATURATION_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_HIGH_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_LOW_THRESHOLD   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SATURATED_COUNT_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_COUNT_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_COUNT_LIMIT   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EVALUATION_LENGTH     = 3'd6;

   // register reset values
   localparam int RST_SATURATION_THRESHOLD  = 32112;
   localparam int RST_POWER_HIGH_THRESHOLD  = 0;
   localparam int RST_POWER_LOW_THRESHOLD   = 0;
   localparam int RST_SATURATED_COUNT_LIMIT = 20;
   localparam int RST_ATTACK_COUNT_LIMIT    = 1;
   localparam int RST_RELEASE_COUNT_LIMIT   = 1;
   localparam int RST_EVALUATION_LENGTH     = 1;

endpackage

@@ rtl/saturation_blow_detector_core.sv @@
// pipeline: an item accepted from req is held in the input register, then moves into the
//   output register, which drives rsp
// throughput: one item per cycle, set by the single compare-and-count stage between the
//   input register and the output register; a stalled rsp stalls req through ready
// reset (synchronous, active high): mode waiting, timer and counters zero, registers at
//   their reset values, both pipeline stages empty
module saturation_blow_detector_core
   import sbd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int POWER_BITS  = 32,
   parameter int COUNT_BITS  = 16,
   localparam int WideBits   = (POWER_BITS > SAMPLE_BITS) ? POWER_BITS : SAMPLE_BITS,
   localparam int CsrBits    = (WideBits > COUNT_BITS) ? WideBits : COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [POWER_BITS-1:0]         req_fast_power,
   input  logic [POWER_BITS-1:0]         req_slow_power,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_detector_state,
   output logic                          rsp_blow_detected,
   // register write port
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CsrBits-1:0]            csr_write_data
);

   // configuration registers
   logic [SAMPLE_BITS-1:0] sat_thresh_ff;
   logic [POWER_BITS-1:0]  pow_high_ff;
   logic [POWER_BITS-1:0]  pow_low_ff;
   logic [COUNT_BITS-1:0]  sat_limit_ff;
   logic [COUNT_BITS-1:0]  attack_limit_ff;
   logic [COUNT_BITS-1:0]  release_limit_ff;
   logic [COUNT_BITS-1:0]  eval_len_ff;

   // detector state
   logic [1:0]            mode_ff, mode_in;
   logic [COUNT_BITS-1:0] timer_ff, timer_in;
   logic [COUNT_BITS-1:0] sat_cnt_ff, sat_cnt_in;
   logic [COUNT_BITS:0]   hit_cnt_ff, hit_cnt_in;

   // input stage
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic [POWER_BITS-1:0]         in_fast_ff;
   logic [POWER_BITS-1:0]         in_slow_ff;

   // output stage
   logic       out_valid_ff;
   logic [1:0] out_state_ff;

   logic advance;   // input stage item moves into the output stage
   logic req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_detector_state = out_state_ff;
   assign rsp_blow_detected  = (out_state_ff == MODE_TRACKING);

   // register writes, indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_thresh_ff    <= SAMPLE_BITS'(RST_SATURATION_THRESHOLD);
         pow_high_ff      <= POWER_BITS'(RST_POWER_HIGH_THRESHOLD);
         pow_low_ff       <= POWER_BITS'(RST_POWER_LOW_THRESHOLD);
         sat_limit_ff     <= COUNT_BITS'(RST_SATURATED_COUNT_LIMIT);
         attack_limit_ff  <= COUNT_BITS'(RST_ATTACK_COUNT_LIMIT);
         release_limit_ff <= COUNT_BITS'(RST_RELEASE_COUNT_LIMIT);
         eval_len_ff      <= COUNT_BITS'(RST_EVALUATION_LENGTH);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SATURATION_THRESHOLD:  sat_thresh_ff    <= csr_write_data[SAMPLE_BITS-1:0];
            CSR_POWER_HIGH_THRESHOLD:  pow_high_ff      <= csr_write_data[POWER_BITS-1:0];
            CSR_POWER_LOW_THRESHOLD:   pow_low_ff       <= csr_write_data[POWER_BITS-1:0];
            CSR_SATURATED_COUNT_LIMIT: sat_limit_ff     <= csr_write_data[COUNT_BITS-1:0];
            CSR_ATTACK_COUNT_LIMIT:    attack_limit_ff  <= csr_write_data[COUNT_BITS-1:0];
            CSR_RELEASE_COUNT_LIMIT:   release_limit_ff <= csr_write_data[COUNT_BITS-1:0];
            CSR_EVALUATION_LENGTH:     eval_len_ff      <= csr_write_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // one detector step per item, evaluated from the input stage
   sbd_step #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .POWER_BITS (POWER_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .sample               (in_sample_ff),
      .fast_power           (in_fast_ff),
      .slow_power           (in_slow_ff),
      .saturation_threshold (sat_thresh_ff),
      .power_high_threshold (pow_high_ff),
      .power_low_threshold  (pow_low_ff),
      .saturated_count_limit(sat_limit_ff),
      .attack_count_limit   (attack_limit_ff),
      .release_count_limit  (release_limit_ff),
      .evaluation_length    (eval_len_ff),
      .cur_mode             (mode_ff),
      .cur_timer            (timer_ff),
      .cur_sat_count        (sat_cnt_ff),
      .cur_hit_count        (hit_cnt_ff),
      .new_mode             (mode_in),
      .new_timer            (timer_in),
      .new_sat_count        (sat_cnt_in),
      .new_hit_count        (hit_cnt_in)
   );

   // state commits only when the item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WAITING;
         timer_ff   <= '0;
         sat_cnt_ff <= '0;
         hit_cnt_ff <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         timer_ff   <= timer_in;
         sat_cnt_ff <= sat_cnt_in;
         hit_cnt_ff <= hit_cnt_in;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample;
         in_fast_ff   <= req_fast_power;
         in_slow_ff   <= req_slow_power;
      end
      if (advance) begin
         out_state_ff <= mode_in;
      end
   end

   // waiting never jumps straight to tracking
   a_no_skip_eval: assert property (@(posedge clock) disable iff (reset)
      advance && (mode_ff == MODE_WAITING) |-> (mode_in != MODE_TRACKING))
      else $error("waiting went straight to tracking");

   // entering tracking starts the release count from zero
   a_track_entry_clear: assert property (@(posedge clock) disable iff (reset)
      advance && (mode_ff == MODE_EVALUATION) && (mode_in == MODE_TRACKING)
      |=> (hit_cnt_ff == '0))
      else $error("hit count not cleared on tracking entry");

   // a step in tracking leaves timer and saturated count at zero
   a_track_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (mode_ff == MODE_TRACKING) |=> (timer_ff == '0) && (sat_cnt_ff == '0))
      else $error("tracking step left timer or saturated count set");

   // a held item in the input stage is not dropped
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff))
      else $error("input stage item lost while stalled");

   // the result register follows the committed mode
   a_result_matches_mode: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_state_ff == mode_ff) && out_valid_ff)
      else $error("result does not match committed mode");

endmodule

@@ rtl/sbd_step.sv @@
module sbd_step
   import sbd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int POWER_BITS  = 32,
   parameter int COUNT_BITS  = 16
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [POWER_BITS-1:0]         fast_power,
   input  logic [POWER_BITS-1:0]         slow_power,
   input  logic [SAMPLE_BITS-1:0]        saturation_threshold,
   input  logic [POWER_BITS-1:0]         power_high_threshold,
   input  logic [POWER_BITS-1:0]         power_low_threshold,
   input  logic [COUNT_BITS-1:0]         saturated_count_limit,
   input  logic [COUNT_BITS-1:0]         attack_count_limit,
   input  logic [COUNT_BITS-1:0]         release_count_limit,
   input  logic [COUNT_BITS-1:0]         evaluation_length,
   input  logic [1:0]                    cur_mode,
   input  logic [COUNT_BITS-1:0]         cur_timer,
   input  logic [COUNT_BITS-1:0]         cur_sat_count,
   input  logic [COUNT_BITS:0]           cur_hit_count,
   output logic [1:0]                    new_mode,
   output logic [COUNT_BITS-1:0]         new_timer,
   output logic [COUNT_BITS-1:0]         new_sat_count,
   output logic [COUNT_BITS:0]           new_hit_count
);

   logic [SAMPLE_BITS-1:0] magnitude;
   logic                   saturated;

   // two's complement magnitude, most negative sample maps to 2^(n-1)
   assign magnitude = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
   assign saturated = magnitude > saturation_threshold;

   always_comb begin
      logic [COUNT_BITS:0]   hit_upd;
      logic [COUNT_BITS-1:0] sat_upd;
      logic [COUNT_BITS-1:0] timer_upd;
      hit_upd       = cur_hit_count;
      sat_upd       = cur_sat_count;
      timer_upd     = cur_timer;
      new_mode      = cur_mode;
      new_timer     = cur_timer;
      new_sat_count = cur_sat_count;
      new_hit_count = cur_hit_count;
      case (cur_mode)
         MODE_TRACKING: begin
            if ((slow_power <= power_low_threshold) && !(&cur_hit_count)) begin
               hit_upd = cur_hit_count + 1'b1;
            end
            new_hit_count = hit_upd;
            if (hit_upd > {1'b0, release_count_limit}) begin
               new_mode = MODE_WAITING;
            end
            new_sat_count = '0;
            new_timer     = '0;
         end
         MODE_EVALUATION: begin
            if (cur_timer != '0) begin
               timer_upd = cur_timer - 1'b1;
            end
            if (saturated && !(&cur_sat_count)) begin
               sat_upd = cur_sat_count + 1'b1;
            end
            if ((fast_power >= power_high_threshold) && !(&cur_hit_count)) begin
               hit_upd = cur_hit_count + 1'b1;
            end
            new_timer     = timer_upd;
            new_sat_count = sat_upd;
            new_hit_count = hit_upd;
            if ((sat_upd > saturated_count_limit) &&
                (hit_upd >= {1'b0, attack_count_limit})) begin
               new_mode      = MODE_TRACKING;
               new_hit_count = '0;
            end else if (timer_upd == '0) begin
               new_mode = MODE_WAITING;
            end
         end
         default: begin
            // waiting, and the unreachable fourth code
            new_hit_count = '0;
            if (saturated) begin
               new_timer     = evaluation_length;
               new_sat_count = '0;
               new_mode      = MODE_EVALUATION;
            end else begin
               new_mode = MODE_WAITING;
            end
         end
      endcase
   end

endmodule
